// File: design/bdf_pkg.sv
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types, sizes and command codes of the bilinear fit-within downscaler.
// ----------------------------------------------------------------------------
package bdf_pkg;

   localparam int MAX_LINE       = 4096;
   localparam int LINE_ADDR_BITS = $clog2(MAX_LINE);
   localparam int MAX_CHANNELS   = 4;
   localparam int SAMPLE_BITS    = 16;
   localparam int SIZE_BITS      = 13;
   localparam int HEIGHT_CAP     = 4096;
   localparam int ROW_BITS       = $clog2(HEIGHT_CAP);
   localparam int CH_BITS        = 3;
   localparam int PIXEL_BITS     = 64;
   localparam int POS_BITS       = 32;
   localparam int RATIO_BITS     = 29;
   localparam int DIV_BITS       = 29;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [15:0] SAMPLE_MASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);
   localparam logic [RATIO_BITS-1:0] ONE_Q16 = RATIO_BITS'(65536);

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_WIDTH     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_HEIGHT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 3'd4;

   // datapath commands
   localparam logic [4:0] OP_IDLE   = 5'd0;
   localparam logic [4:0] OP_ACCEPT = 5'd1;
   localparam logic [4:0] OP_FIT0   = 5'd2;
   localparam logic [4:0] OP_DIV1   = 5'd3;
   localparam logic [4:0] OP_CAP1   = 5'd4;
   localparam logic [4:0] OP_DIV2   = 5'd5;
   localparam logic [4:0] OP_CAP2   = 5'd6;
   localparam logic [4:0] OP_FIT2   = 5'd7;
   localparam logic [4:0] OP_DIVC   = 5'd8;
   localparam logic [4:0] OP_CAPC   = 5'd9;
   localparam logic [4:0] OP_DIVR   = 5'd10;
   localparam logic [4:0] OP_CAPR   = 5'd11;
   localparam logic [4:0] OP_READ   = 5'd12;
   localparam logic [4:0] OP_SCAN   = 5'd13;
   localparam logic [4:0] OP_H0     = 5'd14;
   localparam logic [4:0] OP_H1     = 5'd15;
   localparam logic [4:0] OP_V      = 5'd16;
   localparam logic [4:0] OP_NEXT   = 5'd17;
   localparam logic [4:0] OP_FIN    = 5'd18;

   typedef struct packed {
      logic [15:0] sample_0;
      logic [15:0] sample_1;
      logic [15:0] sample_2;
      logic [15:0] sample_3;
   } req_type;

   typedef struct packed {
      logic [15:0]          out_sample_0;
      logic [15:0]          out_sample_1;
      logic [15:0]          out_sample_2;
      logic [15:0]          out_sample_3;
      logic [SIZE_BITS-1:0] out_width;
      logic [SIZE_BITS-1:0] out_height;
      logic                 frame_last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic frame_start;
      logic need1;
      logic need2;
      logic div_done;
      logic bypass;
      logic emit_none;
      logic last_chan;
      logic last_out;
   } status_type;

endpackage

// File: design/bilinear_downscale_fit.sv
// ----------------------------------------------------------------------------
// bilinear_downscale_fit
// Streaming bilinear downscaler that fits a raster image inside size limits.
// ----------------------------------------------------------------------------
// Source pixels enter on req_* (valid/ready), one pixel per item in raster
// order; results leave on rsp_* with the fitted frame size and an end-of-frame
// flag. The user must write frame size, limits and channel count on csr_*
// only while idle; the block does not enforce this. They are taken at the
// first pixel of each frame, which runs the fit: up to four divisions on the
// shared restoring divider, each with its start and capture. Every pixel
// then goes through accept, line store read and scan, then for each result
// it completes three multiplier passes per channel for four channels, the
// result waiting on the output register until taken, and last a retire; a
// pixel completes 0 to 4 results. A pass-through pixel goes from the scan
// straight to the output register. The next pixel is accepted after the
// last result of the current one is taken; a stalled receiver holds the
// result register and the sequencer waits. Reset clears the counters, ratios
// and config to their defaults; the line store needs no clearing since only
// entries written in the current frame are used.
// ----------------------------------------------------------------------------
module bilinear_downscale_fit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bdf_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bdf_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [bdf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bdf_pkg::SIZE_BITS-1:0]       csr_wdata
);

   bdf_pkg::cmd_type    cmd;
   bdf_pkg::status_type status;

   bdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   bdf_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: design/bdf_ram.sv
// ----------------------------------------------------------------------------
// bdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bdf_div.sv
// ----------------------------------------------------------------------------
// bdf_div
// Restoring divider, one quotient bit per cycle, used for the frame fit.
// ----------------------------------------------------------------------------
module bdf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bdf_pkg::DIV_BITS-1:0]   dividend,
   input  logic [bdf_pkg::SIZE_BITS-1:0]  divisor,
   output logic                           done,
   output logic [bdf_pkg::DIV_BITS-1:0]   quotient
);

   localparam int CNT_BITS = $clog2(bdf_pkg::DIV_BITS + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic [bdf_pkg::SIZE_BITS-1:0] rem_ff, rem_in;
   logic [bdf_pkg::DIV_BITS-1:0]  quo_ff, quo_in;
   logic [bdf_pkg::SIZE_BITS-1:0] dsr_ff, dsr_in;
   logic [bdf_pkg::SIZE_BITS:0]   trial;
   logic                          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[bdf_pkg::DIV_BITS-1]};
      fits  = trial >= {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // dividend bits shift out the top as quotient bits shift in
         rem_in = fits ? bdf_pkg::SIZE_BITS'(trial - {1'b0, dsr_ff})
                       : trial[bdf_pkg::SIZE_BITS-1:0];
         quo_in   = {quo_ff[bdf_pkg::DIV_BITS-2:0], fits};
         count_in = count_ff + CNT_BITS'(1);
         if (count_ff == CNT_BITS'(bdf_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

endmodule

// File: design/bdf_ctrl.sv
// ----------------------------------------------------------------------------
// bdf_ctrl
// Sequencer: frame fit, line read, column/row scan and per-channel blending.
// ----------------------------------------------------------------------------
module bdf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_ready,
   input  bdf_pkg::status_type  status,
   output logic                 req_ready,
   output bdf_pkg::cmd_type     cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_FIT0 = 5'd1;
   localparam logic [4:0] S_CHK1 = 5'd2;
   localparam logic [4:0] S_D1S  = 5'd3;
   localparam logic [4:0] S_D1W  = 5'd4;
   localparam logic [4:0] S_CHK2 = 5'd5;
   localparam logic [4:0] S_D2S  = 5'd6;
   localparam logic [4:0] S_D2W  = 5'd7;
   localparam logic [4:0] S_FIT2 = 5'd8;
   localparam logic [4:0] S_DCS  = 5'd9;
   localparam logic [4:0] S_DCW  = 5'd10;
   localparam logic [4:0] S_DRS  = 5'd11;
   localparam logic [4:0] S_DRW  = 5'd12;
   localparam logic [4:0] S_READ = 5'd13;
   localparam logic [4:0] S_SCAN = 5'd14;
   localparam logic [4:0] S_H0   = 5'd15;
   localparam logic [4:0] S_H1   = 5'd16;
   localparam logic [4:0] S_V    = 5'd17;
   localparam logic [4:0] S_OUT  = 5'd18;
   localparam logic [4:0] S_FIN  = 5'd19;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = bdf_pkg::OP_IDLE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bdf_pkg::OP_ACCEPT;
               state_in = status.frame_start ? S_FIT0 : S_READ;
            end
         end
         S_FIT0: begin
            cmd.op   = bdf_pkg::OP_FIT0;
            state_in = S_CHK1;
         end
         S_CHK1: state_in = status.need1 ? S_D1S : S_CHK2;
         S_D1S: begin
            cmd.op   = bdf_pkg::OP_DIV1;
            state_in = S_D1W;
         end
         S_D1W: begin
            if (status.div_done) begin
               cmd.op   = bdf_pkg::OP_CAP1;
               state_in = S_CHK2;
            end
         end
         S_CHK2: state_in = status.need2 ? S_D2S : S_FIT2;
         S_D2S: begin
            cmd.op   = bdf_pkg::OP_DIV2;
            state_in = S_D2W;
         end
         S_D2W: begin
            if (status.div_done) begin
               cmd.op   = bdf_pkg::OP_CAP2;
               state_in = S_FIT2;
            end
         end
         S_FIT2: begin
            cmd.op   = bdf_pkg::OP_FIT2;
            state_in = S_DCS;
         end
         S_DCS: begin
            cmd.op   = bdf_pkg::OP_DIVC;
            state_in = S_DCW;
         end
         S_DCW: begin
            if (status.div_done) begin
               cmd.op   = bdf_pkg::OP_CAPC;
               state_in = S_DRS;
            end
         end
         S_DRS: begin
            cmd.op   = bdf_pkg::OP_DIVR;
            state_in = S_DRW;
         end
         S_DRW: begin
            if (status.div_done) begin
               cmd.op   = bdf_pkg::OP_CAPR;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.op   = bdf_pkg::OP_READ;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = bdf_pkg::OP_SCAN;
            priority if (status.bypass)    state_in = S_OUT;
            else if (status.emit_none)     state_in = S_FIN;
            else                           state_in = S_H0;
         end
         S_H0: begin
            cmd.op   = bdf_pkg::OP_H0;
            state_in = S_H1;
         end
         S_H1: begin
            cmd.op   = bdf_pkg::OP_H1;
            state_in = S_V;
         end
         S_V: begin
            cmd.op   = bdf_pkg::OP_V;
            state_in = status.last_chan ? S_OUT : S_H0;
         end
         S_OUT: begin
            if (rsp_ready) begin
               cmd.op   = bdf_pkg::OP_NEXT;
               state_in = status.last_out ? S_FIN : S_H0;
            end
         end
         S_FIN: begin
            cmd.op   = bdf_pkg::OP_FIN;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/bdf_datapath.sv
// ----------------------------------------------------------------------------
// bdf_datapath
// Registers, frame fit, line store, position scan and the blend multiplier.
// ----------------------------------------------------------------------------
module bdf_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bdf_pkg::cmd_type                      cmd,
   output bdf_pkg::status_type                   status,
   input  logic                                  csr_we,
   input  logic [bdf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bdf_pkg::SIZE_BITS-1:0]         csr_wdata,
   input  bdf_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   output bdf_pkg::rsp_type                      rsp_payload
);

   localparam int SB = bdf_pkg::SIZE_BITS;
   localparam int AB = bdf_pkg::LINE_ADDR_BITS;
   localparam int RB = bdf_pkg::ROW_BITS;
   localparam int PB = bdf_pkg::POS_BITS;
   localparam int QB = bdf_pkg::RATIO_BITS;
   localparam int XB = bdf_pkg::PIXEL_BITS;

   // configuration
   logic [SB-1:0] cfg_w_ff, cfg_h_ff, cfg_mw_ff, cfg_mh_ff;
   logic [bdf_pkg::CH_BITS-1:0] cfg_ch_ff;

   // frame state
   logic [SB-1:0] frame_w_ff, frame_h_ff, fit_w_ff, fit_h_ff, dw_ff, dh_ff;
   logic [bdf_pkg::CH_BITS-1:0] frame_ch_ff;
   logic          bypass_ff;
   logic [QB-1:0] col_ratio_ff, row_ratio_ff;
   logic [AB-1:0] src_col_ff;
   logic [RB-1:0] src_row_ff;
   logic [SB-1:0] next_col_ff, next_row_ff;
   logic [PB-1:0] col_pos_ff, row_pos_ff;
   logic [XB-1:0] left_cur_ff, left_above_ff;

   // item state
   bdf_pkg::req_type in_ff;
   logic [XB-1:0] cur_ff, above_ff;
   logic [1:0]    nx_ff, ny_ff;
   logic [SB-1:0] xs0_ff, ys0_ff, new_x_ff, new_y_ff;
   logic [PB-1:0] xp0_ff, xp1_ff, yp0_ff, yp1_ff, new_xpos_ff, new_ypos_ff;
   logic          i_ff, j_ff;
   logic [1:0]    k_ff;
   logic [31:0]   h0_ff, h1_ff;
   logic [15:0]   out_lane_ff [4];
   logic [SB-1:0] out_w_ff, out_h_ff;
   logic          out_last_ff, out_valid_ff;

   // divider hookup
   logic                         div_start, div_done;
   logic [bdf_pkg::DIV_BITS-1:0] div_dividend, div_quotient;
   logic [SB-1:0]                div_divisor;
   logic [SB-1:0]                mul_x, mul_y;
   logic [2*SB-1:0]              mul_p;

   // ram hookup
   logic [XB-1:0] ram_rd_data;

   logic [SB-1:0] w_clamp, h_clamp;
   logic [bdf_pkg::CH_BITS-1:0] ch_clamp;
   logic [AB-1:0] c_sig;
   logic [SB-1:0] dwc, dhc;
   logic          byp_new;
   logic          line_end, frame_end;

   // scan
   logic          col_ok0, col_ok1, row_ok0, row_ok1;
   logic [PB-1:0] col_pos1, row_pos1;
   logic [1:0]    nx_c, ny_c;

   // blend
   logic [PB-1:0] xp_sel, yp_sel;
   logic [SB-1:0] xs_sel, ys_sel;
   logic          left_cur, top_cur;
   logic [XB-1:0] px0, px1, px2, px3, pa, pb;
   logic [15:0]   fx, fy, la, lb;
   logic signed [16:0] d17;
   logic signed [33:0] h34;
   logic signed [32:0] d33;
   logic signed [49:0] v50;
   logic          out_is_last;
   logic [XB-1:0] cur_masked;

   function automatic logic pos_hits(input logic [PB-1:0] pos, input logic [SB-1:0] lim,
                                     input logic [SB-1:0] idx);
      logic [16:0] x1;
      logic [16:0] top;
      x1  = {1'b0, pos[PB-1:16]} + 17'd1;
      top = 17'(lim - SB'(1));
      if (x1 > top) x1 = top;
      return x1 == 17'(idx);
   endfunction

   bdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   bdf_ram #(.WIDTH(XB), .DEPTH(bdf_pkg::MAX_LINE)) u_line (
      .clock   (clock),
      .wr_en   (cmd.op == bdf_pkg::OP_SCAN),
      .wr_addr (c_sig),
      .wr_data (cur_ff),
      .rd_en   (cmd.op == bdf_pkg::OP_READ),
      .rd_addr (c_sig),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      // register clamps taken at frame start
      w_clamp = cfg_w_ff;
      if (cfg_w_ff == '0) w_clamp = SB'(1);
      if (cfg_w_ff > SB'(bdf_pkg::MAX_LINE)) w_clamp = SB'(bdf_pkg::MAX_LINE);
      h_clamp = cfg_h_ff;
      if (cfg_h_ff == '0) h_clamp = SB'(1);
      if (cfg_h_ff > SB'(bdf_pkg::HEIGHT_CAP)) h_clamp = SB'(bdf_pkg::HEIGHT_CAP);
      ch_clamp = cfg_ch_ff;
      if (cfg_ch_ff == '0) ch_clamp = bdf_pkg::CH_BITS'(1);
      if (cfg_ch_ff > bdf_pkg::CH_BITS'(bdf_pkg::MAX_CHANNELS))
         ch_clamp = bdf_pkg::CH_BITS'(bdf_pkg::MAX_CHANNELS);

      dwc     = (dw_ff == '0) ? SB'(1) : dw_ff;
      dhc     = (dh_ff == '0) ? SB'(1) : dh_ff;
      byp_new = (cfg_mw_ff == '0 && cfg_mh_ff == '0) ||
                (dwc == frame_w_ff && dhc == frame_h_ff);

      c_sig = ({1'b0, src_col_ff} >= frame_w_ff) ? AB'(frame_w_ff - SB'(1)) : src_col_ff;
      line_end  = {1'b0, c_sig} >= frame_w_ff - SB'(1);
      frame_end = line_end && (({1'b0, src_row_ff} + SB'(1)) >= frame_h_ff);

      // divider operands
      div_start    = cmd.op == bdf_pkg::OP_DIV1 || cmd.op == bdf_pkg::OP_DIV2 ||
                     cmd.op == bdf_pkg::OP_DIVC || cmd.op == bdf_pkg::OP_DIVR;
      mul_x        = (cmd.op == bdf_pkg::OP_DIV2) ? dw_ff : frame_h_ff;
      mul_y        = (cmd.op == bdf_pkg::OP_DIV2) ? cfg_mh_ff : cfg_mw_ff;
      mul_p        = mul_x * mul_y;
      div_dividend = bdf_pkg::DIV_BITS'(mul_p);
      div_divisor  = frame_w_ff;
      unique case (cmd.op)
         bdf_pkg::OP_DIV2: div_divisor = dh_ff;
         bdf_pkg::OP_DIVC: begin
            div_dividend = {frame_w_ff, 16'h0};
            div_divisor  = fit_w_ff;
         end
         bdf_pkg::OP_DIVR: begin
            div_dividend = {frame_h_ff, 16'h0};
            div_divisor  = fit_h_ff;
         end
         default: ;
      endcase

      // up to two output columns and rows can complete on this source pixel
      col_pos1 = col_pos_ff + PB'(col_ratio_ff);
      col_ok0  = (next_col_ff < fit_w_ff) &&
                 pos_hits(col_pos_ff, frame_w_ff, SB'(c_sig));
      col_ok1  = col_ok0 && (({1'b0, next_col_ff} + (SB+1)'(1)) < {1'b0, fit_w_ff}) &&
                 pos_hits(col_pos1, frame_w_ff, SB'(c_sig));
      row_pos1 = row_pos_ff + PB'(row_ratio_ff);
      row_ok0  = (next_row_ff < fit_h_ff) &&
                 pos_hits(row_pos_ff, frame_h_ff, SB'(src_row_ff));
      row_ok1  = row_ok0 && (({1'b0, next_row_ff} + (SB+1)'(1)) < {1'b0, fit_h_ff}) &&
                 pos_hits(row_pos1, frame_h_ff, SB'(src_row_ff));
      nx_c = {col_ok1, col_ok0 & ~col_ok1};
      ny_c = {row_ok1, row_ok0 & ~row_ok1};

      for (int ch = 0; ch < 4; ch++) begin
         cur_masked[16*ch +: 16] = (ch < int'(frame_ch_ff)) ?
                                   (in_ff[16*(3-ch) +: 16] & bdf_pkg::SAMPLE_MASK) : 16'h0;
      end

      // corner selection for the current output pixel
      xp_sel   = j_ff ? xp1_ff : xp0_ff;
      yp_sel   = i_ff ? yp1_ff : yp0_ff;
      xs_sel   = xs0_ff + SB'(j_ff);
      ys_sel   = ys0_ff + SB'(i_ff);
      left_cur = xp_sel[PB-1:16] == 16'(c_sig);
      top_cur  = yp_sel[PB-1:16] == 16'(src_row_ff);
      px0 = top_cur ? (left_cur ? cur_ff : left_cur_ff)
                    : (left_cur ? above_ff : left_above_ff);
      px1 = top_cur ? cur_ff : above_ff;
      px2 = left_cur ? cur_ff : left_cur_ff;
      px3 = cur_ff;
      pa  = (cmd.op == bdf_pkg::OP_H1) ? px2 : px0;
      pb  = (cmd.op == bdf_pkg::OP_H1) ? px3 : px1;
      la  = pa[16*k_ff +: 16];
      lb  = pb[16*k_ff +: 16];
      fx  = xp_sel[15:0];
      fy  = yp_sel[15:0];

      // a*(1-f) + b*f written as a + (b-a)*f, one multiplier per cycle
      d17 = $signed({1'b0, lb}) - $signed({1'b0, la});
      h34 = $signed({2'b00, la, 16'h0}) + d17 * $signed({1'b0, fx});
      d33 = $signed({1'b0, h1_ff}) - $signed({1'b0, h0_ff});
      v50 = $signed({2'b00, h0_ff, 16'h0}) + d33 * $signed({1'b0, fy}) +
            50'sh0_8000_0000;
      out_is_last = ys_sel == fit_h_ff - SB'(1) && xs_sel == fit_w_ff - SB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff      <= SB'(1);
         cfg_h_ff      <= SB'(1);
         cfg_mw_ff     <= '0;
         cfg_mh_ff     <= '0;
         cfg_ch_ff     <= bdf_pkg::CH_BITS'(3);
         frame_w_ff    <= SB'(1);
         frame_h_ff    <= SB'(1);
         frame_ch_ff   <= bdf_pkg::CH_BITS'(3);
         fit_w_ff      <= SB'(1);
         fit_h_ff      <= SB'(1);
         bypass_ff     <= 1'b0;
         col_ratio_ff  <= bdf_pkg::ONE_Q16;
         row_ratio_ff  <= bdf_pkg::ONE_Q16;
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         next_col_ff   <= '0;
         next_row_ff   <= '0;
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         left_cur_ff   <= '0;
         left_above_ff <= '0;
         out_valid_ff  <= 1'b0;
         i_ff          <= 1'b0;
         j_ff          <= 1'b0;
         k_ff          <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bdf_pkg::CSR_SRC_WIDTH:     cfg_w_ff  <= csr_wdata;
               bdf_pkg::CSR_SRC_HEIGHT:    cfg_h_ff  <= csr_wdata;
               bdf_pkg::CSR_MAX_WIDTH:     cfg_mw_ff <= csr_wdata;
               bdf_pkg::CSR_MAX_HEIGHT:    cfg_mh_ff <= csr_wdata;
               bdf_pkg::CSR_CHANNEL_COUNT: cfg_ch_ff <= csr_wdata[bdf_pkg::CH_BITS-1:0];
               default: ;
            endcase
         end
         unique case (cmd.op)
            bdf_pkg::OP_FIT0: begin
               frame_w_ff  <= w_clamp;
               frame_h_ff  <= h_clamp;
               frame_ch_ff <= ch_clamp;
               next_col_ff <= '0;
               next_row_ff <= '0;
               col_pos_ff  <= '0;
               row_pos_ff  <= '0;
            end
            bdf_pkg::OP_FIT2: begin
               bypass_ff <= byp_new;
               fit_w_ff  <= byp_new ? frame_w_ff : dwc;
               fit_h_ff  <= byp_new ? frame_h_ff : dhc;
            end
            bdf_pkg::OP_CAPC: col_ratio_ff <= QB'(div_quotient);
            bdf_pkg::OP_CAPR: row_ratio_ff <= QB'(div_quotient);
            bdf_pkg::OP_SCAN: begin
               i_ff <= 1'b0;
               j_ff <= 1'b0;
               k_ff <= '0;
               if (bypass_ff) out_valid_ff <= 1'b1;
            end
            bdf_pkg::OP_V: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) out_valid_ff <= 1'b1;
            end
            bdf_pkg::OP_NEXT: begin
               out_valid_ff <= 1'b0;
               if (!j_ff && nx_ff == 2'd2) begin
                  j_ff <= 1'b1;
               end else begin
                  j_ff <= 1'b0;
                  i_ff <= ~i_ff;
               end
            end
            bdf_pkg::OP_FIN: begin
               left_above_ff <= above_ff;
               left_cur_ff   <= cur_ff;
               if (!bypass_ff) begin
                  if (line_end) begin
                     next_col_ff <= '0;
                     col_pos_ff  <= '0;
                  end else begin
                     next_col_ff <= new_x_ff;
                     col_pos_ff  <= new_xpos_ff;
                  end
               end
               // end of frame rewinds the output rows
               if (frame_end) begin
                  next_row_ff <= '0;
                  row_pos_ff  <= '0;
               end else if (!bypass_ff && line_end) begin
                  next_row_ff <= new_y_ff;
                  row_pos_ff  <= new_ypos_ff;
               end
               if (line_end) begin
                  src_col_ff <= '0;
                  if (frame_end) begin
                     src_row_ff <= '0;
                  end else begin
                     src_row_ff <= src_row_ff + RB'(1);
                  end
               end else begin
                  src_col_ff <= c_sig + AB'(1);
               end
            end
            default: ;
         endcase
      end

      // payload registers
      unique case (cmd.op)
         bdf_pkg::OP_ACCEPT: in_ff <= req_payload;
         bdf_pkg::OP_FIT0: begin
            dw_ff <= w_clamp;
            dh_ff <= h_clamp;
         end
         bdf_pkg::OP_CAP1: begin
            dh_ff <= SB'(div_quotient);
            dw_ff <= cfg_mw_ff;
         end
         bdf_pkg::OP_CAP2: begin
            dw_ff <= SB'(div_quotient);
            dh_ff <= cfg_mh_ff;
         end
         bdf_pkg::OP_READ: cur_ff <= cur_masked;
         bdf_pkg::OP_SCAN: begin
            above_ff    <= ram_rd_data;
            nx_ff       <= nx_c;
            ny_ff       <= ny_c;
            xs0_ff      <= next_col_ff;
            ys0_ff      <= next_row_ff;
            xp0_ff      <= col_pos_ff;
            xp1_ff      <= col_pos1;
            yp0_ff      <= row_pos_ff;
            yp1_ff      <= row_pos1;
            new_x_ff    <= next_col_ff + SB'(col_ok0) + SB'(col_ok1);
            new_y_ff    <= next_row_ff + SB'(row_ok0) + SB'(row_ok1);
            new_xpos_ff <= col_ok1 ? col_pos1 + PB'(col_ratio_ff) :
                           (col_ok0 ? col_pos1 : col_pos_ff);
            new_ypos_ff <= row_ok1 ? row_pos1 + PB'(row_ratio_ff) :
                           (row_ok0 ? row_pos1 : row_pos_ff);
            for (int ch = 0; ch < 4; ch++) begin
               out_lane_ff[ch] <= cur_ff[16*ch +: 16];
            end
            out_w_ff    <= frame_w_ff;
            out_h_ff    <= frame_h_ff;
            out_last_ff <= ({1'b0, src_row_ff} == frame_h_ff - SB'(1)) &&
                           ({1'b0, c_sig} == frame_w_ff - SB'(1));
         end
         bdf_pkg::OP_H0: h0_ff <= h34[31:0];
         bdf_pkg::OP_H1: h1_ff <= h34[31:0];
         bdf_pkg::OP_V: begin
            out_lane_ff[k_ff] <= v50[47:32] & bdf_pkg::SAMPLE_MASK;
            out_w_ff          <= fit_w_ff;
            out_h_ff          <= fit_h_ff;
            out_last_ff       <= out_is_last;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.frame_start = src_row_ff == '0 && src_col_ff == '0;
      status.need1       = cfg_mw_ff != '0 && frame_w_ff > cfg_mw_ff;
      status.need2       = cfg_mh_ff != '0 && dh_ff > cfg_mh_ff;
      status.div_done    = div_done;
      status.bypass      = bypass_ff;
      status.emit_none   = nx_c == 2'd0 || ny_c == 2'd0;
      status.last_chan   = k_ff == 2'd3;
      status.last_out    = bypass_ff ||
                           ((2'(i_ff) + 2'd1) == ny_ff && (2'(j_ff) + 2'd1) == nx_ff);
   end

   assign rsp_valid = out_valid_ff;
   always_comb begin
      rsp_payload.out_sample_0 = out_lane_ff[0];
      rsp_payload.out_sample_1 = out_lane_ff[1];
      rsp_payload.out_sample_2 = out_lane_ff[2];
      rsp_payload.out_sample_3 = out_lane_ff[3];
      rsp_payload.out_width    = out_w_ff;
      rsp_payload.out_height   = out_h_ff;
      rsp_payload.frame_last   = out_last_ff;
   end

   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      {1'b0, src_col_ff} < frame_w_ff) else $error("source column past line end");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      {1'b0, src_row_ff} < frame_h_ff) else $error("source row past frame end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (cmd.op != bdf_pkg::OP_V && cmd.op != bdf_pkg::OP_H0))
      else $error("result register overwritten while waiting");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bilinear fit-within downscaler.
// ----------------------------------------------------------------------------
// Source frames are streamed pixel by pixel under a series of size, limit and
// channel settings. A behavioral copy of the fit and interpolation runs on
// every accepted pixel and queues its expected output pixels (or a table row
// does); each output handshake is checked field by field against the oldest.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bdf_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bdf_pkg::rsp_type rsp_payload;
   logic             csr_we = 1'b0;
   logic [bdf_pkg::CSR_INDEX_BITS-1:0] csr_index = bdf_pkg::CSR_SRC_WIDTH;
   logic [bdf_pkg::SIZE_BITS-1:0]      csr_wdata = '0;

   bilinear_downscale_fit dut (.*);

   always #5 clock = ~clock;

   // register shadows and frame state of the behavioral scaler
   int unsigned cfg_src_w = 1, cfg_src_h = 1, cfg_max_w = 0, cfg_max_h = 0;
   int unsigned cfg_chans = 3;
   logic [63:0] row_above [0:bdf_pkg::MAX_LINE-1];
   logic [63:0] left_cur = '0, left_above = '0;
   int unsigned src_col = 0, src_row = 0, out_col = 0, out_row = 0;
   int unsigned col_pos = 0, row_pos = 0, col_step = 65536, row_step = 65536;
   int unsigned fit_w = 1, fit_h = 1, frm_w = 1, frm_h = 1, frm_ch = 3;
   bit          pass_thru = 1'b0;

   bdf_pkg::rsp_type pending_pixels [$];
   bdf_pkg::rsp_type new_pixels [$];
   bit          failed = 1'b0;
   int unsigned tx_idle_pct = 0, rx_idle_pct = 0;
   bit          hold_go = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   function automatic longint unsigned lane(logic [63:0] p, int unsigned k);
      return longint'((p >> (16 * k)) & 64'hFFFF);
   endfunction

   function automatic void fit_frame();
      int unsigned w, h, ch, dw, dh;
      w = cfg_src_w; h = cfg_src_h; ch = cfg_chans;
      if (w < 1) w = 1;
      if (w > bdf_pkg::MAX_LINE) w = bdf_pkg::MAX_LINE;
      if (h < 1) h = 1;
      if (h > bdf_pkg::HEIGHT_CAP) h = bdf_pkg::HEIGHT_CAP;
      if (ch < 1) ch = 1;
      if (ch > bdf_pkg::MAX_CHANNELS) ch = bdf_pkg::MAX_CHANNELS;
      frm_w = w; frm_h = h; frm_ch = ch;
      dw = w; dh = h;
      if (cfg_max_w > 0 && dw > cfg_max_w) begin
         dh = (h * cfg_max_w) / w;
         dw = cfg_max_w;
      end
      if (cfg_max_h > 0 && dh > cfg_max_h) begin
         dw = (dw * cfg_max_h) / dh;
         dh = cfg_max_h;
      end
      if (dw < 1) dw = 1;
      if (dh < 1) dh = 1;
      pass_thru = (cfg_max_w == 0 && cfg_max_h == 0) || (dw == w && dh == h);
      fit_w = pass_thru ? w : dw;
      fit_h = pass_thru ? h : dh;
      col_step = int'((longint'(w) << 16) / fit_w);
      row_step = int'((longint'(h) << 16) / fit_h);
      out_col = 0; out_row = 0; col_pos = 0; row_pos = 0;
   endfunction

   // advances the scaler by one source pixel, leaves its outputs in new_pixels
   function automatic void scale_pixel(bdf_pkg::req_type px);
      logic [63:0] cur, above;
      logic [63:0] corner [4];
      logic [15:0] s [4];
      int unsigned r, c, x, y, pos, x1, y1, nx, ny;
      int unsigned xs [2], xp [2], ys [2], yp [2];
      longint unsigned fx, fy, h0, h1, v;
      longint unsigned val [4];
      bdf_pkg::rsp_type o;
      bit top_now, left_now;
      new_pixels.delete();
      if (src_row == 0 && src_col == 0) fit_frame();
      r = src_row; c = src_col;
      if (c >= frm_w) c = frm_w - 1;
      s = '{px.sample_0, px.sample_1, px.sample_2, px.sample_3};
      cur = '0;
      for (int k = 0; k < frm_ch; k++) cur |= 64'(s[k]) << (16 * k);
      above = row_above[c];
      if (pass_thru) begin
         o.out_sample_0 = cur[15:0];
         o.out_sample_1 = cur[31:16];
         o.out_sample_2 = cur[47:32];
         o.out_sample_3 = cur[63:48];
         o.out_width = bdf_pkg::SIZE_BITS'(frm_w);
         o.out_height = bdf_pkg::SIZE_BITS'(frm_h);
         o.frame_last = (r == frm_h - 1 && c == frm_w - 1);
         new_pixels.push_back(o);
      end else begin
         nx = 0; ny = 0;
         x = out_col; pos = col_pos;
         while (nx < 2 && x < fit_w) begin
            x1 = (pos >> 16) + 1;
            if (x1 > frm_w - 1) x1 = frm_w - 1;
            if (x1 != c) break;
            xs[nx] = x; xp[nx] = pos; nx++;
            x++; pos += col_step;
         end
         out_col = x; col_pos = pos;
         y = out_row; pos = row_pos;
         while (ny < 2 && y < fit_h) begin
            y1 = (pos >> 16) + 1;
            if (y1 > frm_h - 1) y1 = frm_h - 1;
            if (y1 != r) break;
            ys[ny] = y; yp[ny] = pos; ny++;
            y++; pos += row_step;
         end
         for (int i = 0; i < ny; i++) begin
            top_now = (yp[i] >> 16) == r;
            fy = yp[i] & 32'hFFFF;
            for (int j = 0; j < nx; j++) begin
               left_now = (xp[j] >> 16) == c;
               fx = xp[j] & 32'hFFFF;
               corner[0] = top_now ? (left_now ? cur : left_cur)
                                   : (left_now ? above : left_above);
               corner[1] = top_now ? cur : above;
               corner[2] = left_now ? cur : left_cur;
               corner[3] = cur;
               for (int k = 0; k < 4; k++) begin
                  h0 = lane(corner[0], k) * (65536 - fx) + lane(corner[1], k) * fx;
                  h1 = lane(corner[2], k) * (65536 - fx) + lane(corner[3], k) * fx;
                  v = h0 * (65536 - fy) + h1 * fy;
                  val[k] = ((v + 64'h8000_0000) >> 32) & 64'hFFFF;
               end
               o.out_sample_0 = val[0][15:0];
               o.out_sample_1 = val[1][15:0];
               o.out_sample_2 = val[2][15:0];
               o.out_sample_3 = val[3][15:0];
               o.out_width = bdf_pkg::SIZE_BITS'(fit_w);
               o.out_height = bdf_pkg::SIZE_BITS'(fit_h);
               o.frame_last = (ys[i] == fit_h - 1 && xs[j] == fit_w - 1);
               new_pixels.push_back(o);
            end
         end
         if (c == frm_w - 1) begin
            out_row = y; row_pos = pos;
            out_col = 0; col_pos = 0;
         end
      end
      left_above = above;
      row_above[c] = cur;
      left_cur = cur;
      if (c >= frm_w - 1) begin
         src_col = 0;
         src_row++;
         if (src_row >= frm_h) begin
            src_row = 0; out_row = 0; row_pos = 0;
         end
      end else begin
         src_col = c + 1;
      end
   endfunction

   task automatic offer_pixel(bdf_pkg::req_type px, bit typed, bdf_pkg::rsp_type want);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (!req_ready);
      scale_pixel(px);
      if (typed) pending_pixels.push_back(want);
      else foreach (new_pixels[i]) pending_pixels.push_back(new_pixels[i]);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frames(int unsigned frames, output int unsigned sent);
      int unsigned w, h;
      bdf_pkg::req_type px;
      w = (cfg_src_w < 1) ? 1 : (cfg_src_w > bdf_pkg::MAX_LINE) ? bdf_pkg::MAX_LINE
                                                                  : cfg_src_w;
      h = (cfg_src_h < 1) ? 1 : (cfg_src_h > bdf_pkg::HEIGHT_CAP) ? bdf_pkg::HEIGHT_CAP
                                                                    : cfg_src_h;
      sent = w * h * frames;
      for (int n = 0; n < sent; n++) begin
         px = '{pick_sample(), pick_sample(), pick_sample(), pick_sample()};
         offer_pixel(px, 1'b0, '0);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [bdf_pkg::CSR_INDEX_BITS-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bdf_pkg::SIZE_BITS'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         bdf_pkg::CSR_SRC_WIDTH:     cfg_src_w = value & 13'h1FFF;
         bdf_pkg::CSR_SRC_HEIGHT:    cfg_src_h = value & 13'h1FFF;
         bdf_pkg::CSR_MAX_WIDTH:     cfg_max_w = value & 13'h1FFF;
         bdf_pkg::CSR_MAX_HEIGHT:    cfg_max_h = value & 13'h1FFF;
         bdf_pkg::CSR_CHANNEL_COUNT: cfg_chans = value & 7;
         default: ;
      endcase
   endtask

   task automatic setup(int unsigned sw, sh, mw, mh, ch);
      write_reg(bdf_pkg::CSR_SRC_WIDTH, sw);
      write_reg(bdf_pkg::CSR_SRC_HEIGHT, sh);
      write_reg(bdf_pkg::CSR_MAX_WIDTH, mw);
      write_reg(bdf_pkg::CSR_MAX_HEIGHT, mh);
      write_reg(bdf_pkg::CSR_CHANNEL_COUNT, ch);
   endtask

   typedef struct {
      bdf_pkg::req_type px;
      bit               typed;
      bdf_pkg::rsp_type want;
   } pixel_row_type;

   // reset settings: 1x1 frame, no limits, three channels, so each pixel
   // comes back as-is with channel 3 cleared
   pixel_row_type reset_rows [6] = '{
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'd1, 13'd1, 1'b1}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 13'd1, 13'd1, 1'b1}},
      '{'{16'hA5A5, 16'h5A5A, 16'hAAAA, 16'h5555}, 1'b1,
        '{16'hA5A5, 16'h5A5A, 16'hAAAA, 16'h0000, 13'd1, 13'd1, 1'b1}},
      '{'{16'h5A5A, 16'hA5A5, 16'h5555, 16'hAAAA}, 1'b1,
        '{16'h5A5A, 16'hA5A5, 16'h5555, 16'h0000, 13'd1, 13'd1, 1'b1}},
      '{'{16'h0001, 16'h8000, 16'h00FF, 16'hFF00}, 1'b1,
        '{16'h0001, 16'h8000, 16'h00FF, 16'h0000, 13'd1, 13'd1, 1'b1}},
      '{'{16'h1234, 16'hFEDC, 16'h8001, 16'h7FFE}, 1'b0, '0}
   };

   typedef struct {
      int unsigned sw, sh, mw, mh, ch, frames;
   } phase_type;

   phase_type directed_phases [10] = '{
      '{3, 3, 2, 0, 4, 1},      // downscale by the width limit, four channels
      '{5, 4, 0, 3, 1, 1},      // height limit only, one channel
      '{8, 8, 9, 9, 4, 1},      // limits above the size pass through
      '{2, 2, 1, 1, 0, 1},      // single output pixel, channel count zero
      '{0, 3, 0, 2, 7, 1},      // zero width saturates, too many channels
      '{6, 3, 4, 1, 3, 2},      // both limits bite
      '{4, 4, 4, 0, 2, 1},      // limit equal to size passes through
      '{7, 5, 3, 2, 4, 1},
      '{20, 1, 1, 0, 4, 1},     // wide line down to one pixel
      '{1, 20, 0, 1, 2, 1}      // tall column down to one pixel
   };

   // result side: ready pattern, long hold-off and checking
   always @(negedge clock) begin
      if (hold_go && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 0) hold_go = 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      bdf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("output pixel with nothing expected: %h", rsp_payload);
            failed = 1'b1;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.out_sample_0 !== want.out_sample_0) begin
               $error("out_sample_0 expected %h got %h",
                      want.out_sample_0, rsp_payload.out_sample_0);
               failed = 1'b1;
            end
            if (rsp_payload.out_sample_1 !== want.out_sample_1) begin
               $error("out_sample_1 expected %h got %h",
                      want.out_sample_1, rsp_payload.out_sample_1);
               failed = 1'b1;
            end
            if (rsp_payload.out_sample_2 !== want.out_sample_2) begin
               $error("out_sample_2 expected %h got %h",
                      want.out_sample_2, rsp_payload.out_sample_2);
               failed = 1'b1;
            end
            if (rsp_payload.out_sample_3 !== want.out_sample_3) begin
               $error("out_sample_3 expected %h got %h",
                      want.out_sample_3, rsp_payload.out_sample_3);
               failed = 1'b1;
            end
            if (rsp_payload.out_width !== want.out_width) begin
               $error("out_width expected %0d got %0d",
                      want.out_width, rsp_payload.out_width);
               failed = 1'b1;
            end
            if (rsp_payload.out_height !== want.out_height) begin
               $error("out_height expected %0d got %0d",
                      want.out_height, rsp_payload.out_height);
               failed = 1'b1;
            end
            if (rsp_payload.frame_last !== want.frame_last) begin
               $error("frame_last expected %0d got %0d",
                      want.frame_last, rsp_payload.frame_last);
               failed = 1'b1;
            end
         end
      end
      // watchdog on handshake activity
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned sent, random_items, sw, sh;
      for (int i = 0; i < bdf_pkg::MAX_LINE; i++) row_above[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 24; rx_idle_pct = 61;
      foreach (reset_rows[i]) offer_pixel(reset_rows[i].px, reset_rows[i].typed,
                                          reset_rows[i].want);
      drain();

      foreach (directed_phases[i]) begin
         setup(directed_phases[i].sw, directed_phases[i].sh, directed_phases[i].mw,
               directed_phases[i].mh, directed_phases[i].ch);
         // receiver holds off while a pass-through frame keeps coming
         if (i == 2) hold_go = 1'b1;
         send_frames(directed_phases[i].frames, sent);
         drain();
      end

      random_items = 0;
      while (random_items < 120) begin
         if (random_items < 40) begin
            tx_idle_pct = 24; rx_idle_pct = 61;
         end else if (random_items < 80) begin
            tx_idle_pct = 61; rx_idle_pct = 24;
         end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         sw = $urandom_range(1, 6);
         sh = $urandom_range(1, 6);
         setup(sw, sh,
               ($urandom_range(3) == 0) ? 0 : $urandom_range(1, sw + 2),
               ($urandom_range(3) == 0) ? 0 : $urandom_range(1, sh + 2),
               $urandom_range(0, 7));
         send_frames($urandom_range(1, 2), sent);
         random_items += sent;
         drain();
      end

      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
